>>> rtl/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared widths, register indexes and reset values of the harmonic PR
// controller.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int GAIN_W    = 24;
    localparam int LIMIT_W   = 15;
    localparam int SAMPLE_W  = 16;
    localparam int ERR_W     = 17;
    localparam int STATE_W   = 32;
    localparam int CFG_AW    = 3;

    localparam logic [CFG_AW-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_FUND_GAIN  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_THIRD_GAIN = 3'd2;
    localparam logic [CFG_AW-1:0] REG_FIFTH_GAIN = 3'd3;
    localparam logic [CFG_AW-1:0] REG_FUND_STEP  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_THIRD_STEP = 3'd5;
    localparam logic [CFG_AW-1:0] REG_FIFTH_STEP = 3'd6;
    localparam logic [CFG_AW-1:0] REG_OUT_LIMIT  = 3'd7;

    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN  = 24'd1258291;
    localparam logic [GAIN_W-1:0]  RST_FUND_GAIN  = 24'd19508;
    localparam logic [GAIN_W-1:0]  RST_THIRD_GAIN = 24'd599;
    localparam logic [GAIN_W-1:0]  RST_FIFTH_GAIN = 24'd420;
    localparam logic [GAIN_W-1:0]  RST_FUND_STEP  = 24'd131768;
    localparam logic [GAIN_W-1:0]  RST_THIRD_STEP = 24'd395303;
    localparam logic [GAIN_W-1:0]  RST_FIFTH_STEP = 24'd658839;
    localparam logic [LIMIT_W-1:0] RST_OUT_LIMIT  = 15'd7987;

    typedef enum logic [3:0] {
        OP_ERR  = 4'b0001,
        OP_VEL  = 4'b0010,
        OP_POS  = 4'b0100,
        OP_PROP = 4'b1000
    } op_t;

endpackage

>>> rtl/prc_mul.sv
// ----------------------------------------------------------------------------
// prc_mul
// Bit-serial multiplier: unsigned gain times signed operand, one gain bit
// per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module prc_mul #(
    parameter int XW = prc_pkg::STATE_W,
    parameter int PW = XW + prc_pkg::GAIN_W
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [prc_pkg::GAIN_W-1:0] gain,
    input  logic signed [XW-1:0]       x,
    output logic                       done,
    output logic signed [PW-1:0]       product
);

    localparam int CW = $clog2(prc_pkg::GAIN_W);

    logic                       run_reg;
    logic                       done_reg;
    logic [CW-1:0]              cnt_reg;
    logic [prc_pkg::GAIN_W-1:0] gsh_reg;
    logic signed [XW-1:0]       x_reg;
    logic signed [PW-1:0]       acc_reg;
    logic signed [PW-1:0]       acc_next;

    assign acc_next = (acc_reg <<< 1) +
                      (gsh_reg[prc_pkg::GAIN_W-1] ? PW'(x_reg) : PW'(0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(prc_pkg::GAIN_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            gsh_reg <= gain;
            x_reg   <= x;
            acc_reg <= '0;
        end else if (run_reg) begin
            gsh_reg <= gsh_reg << 1;
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> rtl/pr_controller_harmonic.sv
// A run transaction takes ten serial multiplies (error, velocity and position
// for each harmonic, then proportional), plus load, clamp and hand-off.
// A clear transaction zeroes the resonator state and goes straight to hand-off.
// Only one transaction at a time: the next is accepted after hand-off.
// Reset (aresetn low, synchronous) zeroes the controller state, except the
// output drive and flags, and loads the default gains, steps and limit.
// ----------------------------------------------------------------------------
// pr_controller_harmonic
// Proportional-resonant controller with resonant terms at the fundamental,
// third and fifth harmonics, sequenced over one bit-serial multiplier.
// ----------------------------------------------------------------------------
module pr_controller_harmonic #(
    parameter int STATE_WIDTH = prc_pkg::STATE_W
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // ref_req[15:0], fdb[31:16]
    input  logic                        s_tuser,   // command
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,   // drive[15:0], sat_high, sat_low
    input  logic                        cfg_we,
    input  logic [prc_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [prc_pkg::GAIN_W-1:0]  cfg_wdata
);

    localparam int SW   = STATE_WIDTH;
    localparam int PW   = SW + prc_pkg::GAIN_W;
    localparam int SUMW = SW + 14;
    localparam int AW   = SUMW + 2;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_MUL   = 5'b00100,
        S_CLAMP = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t        state_reg;
    prc_pkg::op_t  op_reg;
    logic [1:0]    h_reg;

    logic [prc_pkg::GAIN_W-1:0]  kp_reg;
    logic [prc_pkg::GAIN_W-1:0]  k_reg [3];
    logic [prc_pkg::GAIN_W-1:0]  w_reg [3];
    logic [prc_pkg::LIMIT_W-1:0] lim_reg;

    logic signed [prc_pkg::ERR_W-1:0] perr_reg;
    logic signed [prc_pkg::ERR_W-1:0] err_reg;
    logic signed [SW-1:0]             pos_reg [3];
    logic signed [SW-1:0]             vel_reg [3];
    logic signed [AW-1:0]             sum_reg;

    logic        mv_reg;
    logic [15:0] drive_reg;
    logic        hi_reg;
    logic        lo_reg;
    logic [15:0] rdrive_reg;
    logic        rhi_reg;
    logic        rlo_reg;

    logic                       mul_start;
    logic [prc_pkg::GAIN_W-1:0] mul_gain;
    logic signed [SW-1:0]       mul_x;
    logic                       mul_done;
    logic signed [PW-1:0]       mul_prod;

    logic signed [PW-1:0]   r12_full;
    logic signed [PW-1:0]   r22_full;
    logic signed [SUMW-1:0] r12;
    logic signed [SUMW-1:0] r22;

    logic signed [AW-1:0] lim;
    logic signed [AW-1:0] clamp_o;
    logic signed [AW-1:0] diff;
    logic signed [AW-1:0] dsum;
    logic                 clamp_hi;
    logic                 clamp_lo;

    function automatic logic signed [SW-1:0] sat_sw(input logic signed [AW-1:0] v);
        logic same;
        same = (v[AW-1:SW-1] == {(AW-SW+1){1'b0}}) || (v[AW-1:SW-1] == {(AW-SW+1){1'b1}});
        if (same) begin
            return v[SW-1:0];
        end
        return {v[AW-1], {(SW-1){~v[AW-1]}}};
    endfunction

    function automatic logic signed [prc_pkg::ERR_W-1:0] ERR_W_EXT(input logic [15:0] v);
        return {v[15], v};
    endfunction

    prc_mul #(.XW(SW), .PW(PW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .gain    (mul_gain),
        .x       (mul_x),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign mul_start = (state_reg == S_LOAD);
    assign m_tvalid  = mv_reg;
    assign m_tdata   = {6'd0, lo_reg, hi_reg, drive_reg};

    always_comb begin
        mul_gain = kp_reg;
        mul_x    = SW'(err_reg);
        unique case (op_reg)
            prc_pkg::OP_ERR: begin
                mul_gain = k_reg[h_reg];
                mul_x    = SW'(perr_reg);
            end
            prc_pkg::OP_VEL: begin
                mul_gain = w_reg[h_reg];
                mul_x    = vel_reg[h_reg];
            end
            prc_pkg::OP_POS: begin
                mul_gain = w_reg[h_reg];
                mul_x    = pos_reg[h_reg];
            end
            default: begin
                mul_gain = kp_reg;
                mul_x    = SW'(err_reg);
            end
        endcase
    end

    assign r12_full = (mul_prod + (PW'(1) <<< 11)) >>> 12;
    assign r22_full = (mul_prod + (PW'(1) <<< 21)) >>> 22;
    assign r12      = r12_full[SUMW-1:0];
    assign r22      = r22_full[SUMW-1:0];

    assign lim      = AW'({lim_reg, 10'd0});
    assign clamp_hi = (sum_reg > lim);
    assign clamp_lo = (sum_reg < -lim);
    assign clamp_o  = clamp_hi ? lim : (clamp_lo ? -lim : sum_reg);
    assign diff     = clamp_o - sum_reg;
    assign dsum     = clamp_o + AW'(512);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg   <= prc_pkg::RST_PROP_GAIN;
            k_reg[0] <= prc_pkg::RST_FUND_GAIN;
            k_reg[1] <= prc_pkg::RST_THIRD_GAIN;
            k_reg[2] <= prc_pkg::RST_FIFTH_GAIN;
            w_reg[0] <= prc_pkg::RST_FUND_STEP;
            w_reg[1] <= prc_pkg::RST_THIRD_STEP;
            w_reg[2] <= prc_pkg::RST_FIFTH_STEP;
            lim_reg  <= prc_pkg::RST_OUT_LIMIT;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                prc_pkg::REG_PROP_GAIN:  kp_reg   <= cfg_wdata;
                prc_pkg::REG_FUND_GAIN:  k_reg[0] <= cfg_wdata;
                prc_pkg::REG_THIRD_GAIN: k_reg[1] <= cfg_wdata;
                prc_pkg::REG_FIFTH_GAIN: k_reg[2] <= cfg_wdata;
                prc_pkg::REG_FUND_STEP:  w_reg[0] <= cfg_wdata;
                prc_pkg::REG_THIRD_STEP: w_reg[1] <= cfg_wdata;
                prc_pkg::REG_FIFTH_STEP: w_reg[2] <= cfg_wdata;
                default:                 lim_reg  <= cfg_wdata[prc_pkg::LIMIT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= prc_pkg::OP_ERR;
            h_reg     <= 2'd0;
            perr_reg  <= '0;
            err_reg   <= '0;
            sum_reg   <= '0;
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
            mv_reg     <= 1'b0;
            rdrive_reg <= '0;
            rhi_reg    <= 1'b0;
            rlo_reg    <= 1'b0;
        end else begin
            if (state_reg == S_DONE && (!mv_reg || m_tready)) begin
                mv_reg <= 1'b1;
            end else if (mv_reg && m_tready) begin
                mv_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser) begin
                            perr_reg <= '0;
                            for (int i = 0; i < 3; i++) begin
                                pos_reg[i] <= '0;
                                vel_reg[i] <= '0;
                            end
                            rdrive_reg <= '0;
                            rhi_reg    <= 1'b0;
                            rlo_reg    <= 1'b0;
                            state_reg  <= S_DONE;
                        end else begin
                            err_reg   <= ERR_W_EXT(s_tdata[15:0]) - ERR_W_EXT(s_tdata[31:16]);
                            op_reg    <= prc_pkg::OP_ERR;
                            h_reg     <= 2'd0;
                            state_reg <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    if (mul_done) begin
                        state_reg <= S_LOAD;
                        unique case (op_reg)
                            prc_pkg::OP_ERR: begin
                                sum_reg <= AW'(pos_reg[h_reg]) + AW'(r12);
                                op_reg  <= prc_pkg::OP_VEL;
                            end
                            prc_pkg::OP_VEL: begin
                                pos_reg[h_reg] <= sat_sw(sum_reg + AW'(r22));
                                op_reg         <= prc_pkg::OP_POS;
                            end
                            prc_pkg::OP_POS: begin
                                vel_reg[h_reg] <= sat_sw(AW'(vel_reg[h_reg]) - AW'(r22));
                                if (h_reg == 2'd2) begin
                                    op_reg <= prc_pkg::OP_PROP;
                                end else begin
                                    op_reg <= prc_pkg::OP_ERR;
                                    h_reg  <= h_reg + 2'd1;
                                end
                            end
                            default: begin
                                sum_reg   <= AW'(r12) + AW'(pos_reg[0]) + AW'(pos_reg[1])
                                             + AW'(pos_reg[2]);
                                state_reg <= S_CLAMP;
                            end
                        endcase
                    end
                end
                S_CLAMP: begin
                    for (int i = 0; i < 3; i++) begin
                        pos_reg[i] <= sat_sw(AW'(pos_reg[i]) + diff);
                    end
                    perr_reg   <= err_reg;
                    rdrive_reg <= dsum[25:10];
                    rhi_reg    <= clamp_hi;
                    rlo_reg    <= clamp_lo;
                    state_reg  <= S_DONE;
                end
                default: begin
                    if (!mv_reg || m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && (!mv_reg || m_tready)) begin
            drive_reg <= rdrive_reg;
            hi_reg    <= rhi_reg;
            lo_reg    <= rlo_reg;
        end
    end

    a_sat_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[16] && m_tdata[17]))
        else $error("sat_high and sat_low both set");

    a_done_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == S_MUL))
        else $error("multiplier finished outside the multiply phase");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=>
            (pos_reg[0] == '0 && vel_reg[2] == '0 && perr_reg == '0))
        else $error("clear transaction left controller state");

    a_start_idle_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |=> (state_reg == S_MUL && !mul_done))
        else $error("multiply start not followed by multiply phase");

endmodule
